@@ src/fsg_pkg.sv @@
// Package for the Fibonacci sphere point generator: fixed-point constants,
// register codes, pipeline latencies and shared arithmetic helpers.
// No dependencies.
package fsg_pkg;

   localparam int INDEX_BITS_DEF = 16;
   localparam int COORD_BITS_DEF = 16;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] REG_POINT_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_START_ANGLE = 2'd1;

   localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
   localparam logic [31:0] GOLDEN_TURN = 32'h61C8_8647;
   localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;

   localparam int DIV_STAGES  = 31;
   localparam int SQRT_STAGES = 31;
   localparam int HGT_LAT     = DIV_STAGES + 3 + SQRT_STAGES;
   localparam int TRG_LAT     = 15;
   localparam int OUT_STAGES  = 2;

   // Exact reciprocals for 30-bit numerators: floor(2^(30+l)/K) + 1.
   localparam int unsigned SH_72 = 37;
   localparam int unsigned SH_42 = 36;
   localparam int unsigned SH_20 = 35;
   localparam int unsigned SH_6  = 33;
   localparam int unsigned SH_90 = 37;
   localparam int unsigned SH_56 = 36;
   localparam int unsigned SH_30 = 35;
   localparam int unsigned SH_12 = 34;
   localparam logic [30:0] RCP_72 = 31'(((64'd1 << 37) / 64'd72) + 64'd1);
   localparam logic [30:0] RCP_42 = 31'(((64'd1 << 36) / 64'd42) + 64'd1);
   localparam logic [30:0] RCP_20 = 31'(((64'd1 << 35) / 64'd20) + 64'd1);
   localparam logic [30:0] RCP_6  = 31'(((64'd1 << 33) / 64'd6) + 64'd1);
   localparam logic [30:0] RCP_90 = 31'(((64'd1 << 37) / 64'd90) + 64'd1);
   localparam logic [30:0] RCP_56 = 31'(((64'd1 << 36) / 64'd56) + 64'd1);
   localparam logic [30:0] RCP_30 = 31'(((64'd1 << 35) / 64'd30) + 64'd1);
   localparam logic [30:0] RCP_12 = 31'(((64'd1 << 34) / 64'd12) + 64'd1);

   function automatic logic [29:0] div_rcp(input logic [29:0] num, input logic [30:0] rcp,
                                           input int unsigned shift);
      logic [60:0] prod;
      prod = 61'(num) * 61'(rcp);
      return 30'(prod >> shift);
   endfunction

   // Q30 product of two magnitudes of at most 1.0, truncated.
   function automatic logic [30:0] mul_q30(input logic [30:0] x, input logic [30:0] y);
      logic [61:0] prod;
      prod = 62'(x) * 62'(y);
      return 31'(prod >> 30);
   endfunction

endpackage

@@ src/fibonacci_sphere_point_generator_top.sv @@
// Fibonacci sphere point generator, top level. Uses fsg_pkg, fsg_height, fsg_trig.
// One index is accepted every cycle and busy is low whenever reset is low.
// The latency is set by the 31-stage divider and the 31-stage square root in series.
// Reset sets point_count to 1 and start_angle to 0 and drops all transfers in flight.
module fibonacci_sphere_point_generator_top #(
   parameter int INDEX_BITS = fsg_pkg::INDEX_BITS_DEF,
   parameter int COORD_BITS = fsg_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [15:0]                         req_point_index,
   input  logic                                csr_write_en,
   input  logic [fsg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fsg_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output logic                                rsp_strobe,
   output logic signed [COORD_BITS-1:0]        rsp_coord_x,
   output logic signed [COORD_BITS-1:0]        rsp_coord_y,
   output logic signed [COORD_BITS-1:0]        rsp_coord_z,
   output logic                                rsp_valid_res
);
   import fsg_pkg::*;

   localparam int PIPE_LAT = HGT_LAT + OUT_STAGES;
   localparam int IDX_DLY  = HGT_LAT - TRG_LAT;
   localparam int RSH      = (COORD_BITS >= 31) ? 0 : 31 - COORD_BITS;
   localparam int LSH      = (COORD_BITS >= 31) ? COORD_BITS - 31 : 0;
   localparam logic [32:0] HALF = (33'd1 << RSH) >> 1;
   localparam logic [32:0] LIM  = 33'd1 << (COORD_BITS - 1);

   logic [INDEX_BITS-1:0] count_ff;
   logic [15:0]           angle_ff;
   logic                  accept;
   logic [INDEX_BITS-1:0] idx_w;
   logic                  vld_ff  [0:PIPE_LAT-1];
   logic                  inr_ff  [0:PIPE_LAT-1];
   logic [INDEX_BITS-1:0] idly_ff [0:IDX_DLY-1];

   logic [30:0] ymag, rad, cmag, smag;
   logic        yneg, cneg, sneg;
   logic [30:0] xm_ff, zm_ff, ym_ff;
   logic        xn_ff, zn_ff, yn_ff;
   logic [COORD_BITS-1:0] x_in, y_in, z_in, x_ff, y_ff, z_ff;
   logic                  vres_ff;

   function automatic logic [COORD_BITS-1:0] to_coord(input logic neg, input logic [30:0] mag);
      logic [32:0] m;
      m = ((33'(mag) + HALF) >> RSH) << LSH;
      if (neg) begin
         if (m > LIM) m = LIM;
         return COORD_BITS'(33'd0 - m);
      end
      if (m > LIM - 33'd1) m = LIM - 33'd1;
      return COORD_BITS'(m);
   endfunction

   assign busy   = reset;
   assign accept = start && !busy;
   assign idx_w  = INDEX_BITS'(req_point_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= INDEX_BITS'(1);
         angle_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_POINT_COUNT: count_ff <= INDEX_BITS'(csr_wdata);
            REG_START_ANGLE: angle_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_LAT; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
         for (int k = 1; k < PIPE_LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      inr_ff[0]  <= idx_w < count_ff;
      idly_ff[0] <= idx_w;
      for (int k = 1; k < PIPE_LAT; k++) inr_ff[k] <= inr_ff[k-1];
      for (int k = 1; k < IDX_DLY; k++) idly_ff[k] <= idly_ff[k-1];
   end

   fsg_height #(.IDX_W(INDEX_BITS)) u_height (
      .clock  (clock),
      .idx_in (idx_w),
      .count  (count_ff),
      .ymag   (ymag),
      .yneg   (yneg),
      .rad    (rad)
   );

   fsg_trig #(.IDX_W(INDEX_BITS)) u_trig (
      .clock       (clock),
      .idx_in      (idly_ff[IDX_DLY-1]),
      .start_angle (angle_ff),
      .cos_mag     (cmag),
      .cos_neg     (cneg),
      .sin_mag     (smag),
      .sin_neg     (sneg)
   );

   assign x_in = inr_ff[PIPE_LAT-2] ? to_coord(xn_ff, xm_ff) : '0;
   assign y_in = inr_ff[PIPE_LAT-2] ? to_coord(yn_ff, ym_ff) : '0;
   assign z_in = inr_ff[PIPE_LAT-2] ? to_coord(zn_ff, zm_ff) : '0;

   always_ff @(posedge clock) begin
      xm_ff   <= mul_q30(cmag, rad);
      zm_ff   <= mul_q30(smag, rad);
      ym_ff   <= ymag;
      xn_ff   <= cneg;
      zn_ff   <= sneg;
      yn_ff   <= yneg;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      vres_ff <= inr_ff[PIPE_LAT-2];
   end

   assign rsp_strobe    = vld_ff[PIPE_LAT-1];
   assign rsp_coord_x   = x_ff;
   assign rsp_coord_y   = y_ff;
   assign rsp_coord_z   = z_ff;
   assign rsp_valid_res = vres_ff;

`ifndef SYNTH
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(start && !busy, PIPE_LAT))
      else $error("result strobe does not follow an accepted index");

   a_out_of_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_valid_res |->
         (rsp_coord_x == '0 && rsp_coord_y == '0 && rsp_coord_z == '0))
      else $error("out-of-range result has nonzero coordinates");

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy is high outside reset");
`endif

endmodule

@@ src/fsg_height.sv @@
// Height and ring radius pipeline: restoring divider for the height,
// square of the height and a digit-by-digit square root. Uses fsg_pkg.
module fsg_height #(
   parameter int IDX_W = fsg_pkg::INDEX_BITS_DEF
) (
   input  logic             clock,
   input  logic [IDX_W-1:0] idx_in,
   input  logic [IDX_W-1:0] count,
   output logic [30:0]      ymag,
   output logic             yneg,
   output logic [30:0]      rad
);
   import fsg_pkg::*;

   logic [IDX_W-1:0] drem_in [0:DIV_STAGES-1];
   logic [IDX_W-1:0] drem_ff [0:DIV_STAGES-1];
   logic [30:0]      dq_in   [0:DIV_STAGES-1];
   logic [30:0]      dq_ff   [0:DIV_STAGES-1];

   logic [30:0] quo;
   logic        yneg_in, yneg_ff, yneg2_ff;
   logic [30:0] ymag_in, ymag_ff, ymag2_ff;
   logic [30:0] y2_in, y2_ff;

   logic [30:0] sv_ff    [0:SQRT_STAGES];
   logic [30:0] sm_ff    [0:SQRT_STAGES];
   logic        sn_ff    [0:SQRT_STAGES];
   logic [32:0] srem_in  [1:SQRT_STAGES];
   logic [32:0] srem_ff  [1:SQRT_STAGES];
   logic [30:0] sroot_in [1:SQRT_STAGES];
   logic [30:0] sroot_ff [1:SQRT_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      logic [IDX_W:0] dsh;
      logic [30:0]    dq_prev;
      logic           dge;
      if (s == 0) begin : g_first
         assign dsh     = {1'b0, idx_in};
         assign dq_prev = '0;
      end else if (s == 1) begin : g_half
         assign dsh     = {drem_ff[s-1], 1'b1};
         assign dq_prev = dq_ff[s-1];
      end else begin : g_rest
         assign dsh     = {drem_ff[s-1], 1'b0};
         assign dq_prev = dq_ff[s-1];
      end
      assign dge        = dsh >= {1'b0, count};
      assign drem_in[s] = dge ? IDX_W'(dsh - {1'b0, count}) : dsh[IDX_W-1:0];
      assign dq_in[s]   = {dq_prev[29:0], dge};
   end

   assign quo     = dq_ff[DIV_STAGES-1];
   assign yneg_in = quo > Q30_ONE;
   assign ymag_in = yneg_in ? (quo - Q30_ONE) : (Q30_ONE - quo);
   assign y2_in   = mul_q30(ymag_ff, ymag_ff);

   for (genvar s = 1; s <= SQRT_STAGES; s++) begin : g_sqrt
      localparam int K = SQRT_STAGES - s;
      logic [31:0] vx;
      logic [1:0]  pair;
      logic [32:0] rem_prev;
      logic [30:0] root_prev;
      logic [34:0] rem_sh;
      logic [34:0] trial;
      logic        sge;
      assign vx = {1'b0, sv_ff[s-1]};
      if (K >= 15) begin : g_data
         assign pair = {vx[2*K-29], vx[2*K-30]};
      end else begin : g_zero
         assign pair = 2'b00;
      end
      if (s == 1) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_rest
         assign rem_prev  = srem_ff[s-1];
         assign root_prev = sroot_ff[s-1];
      end
      assign rem_sh      = {rem_prev, pair};
      assign trial       = {2'b00, root_prev, 2'b01};
      assign sge         = rem_sh >= trial;
      assign srem_in[s]  = sge ? 33'(rem_sh - trial) : 33'(rem_sh);
      assign sroot_in[s] = {root_prev[29:0], sge};
   end

   always_ff @(posedge clock) begin
      drem_ff  <= drem_in;
      dq_ff    <= dq_in;
      yneg_ff  <= yneg_in;
      ymag_ff  <= ymag_in;
      y2_ff    <= y2_in;
      ymag2_ff <= ymag_ff;
      yneg2_ff <= yneg_ff;
      sv_ff[0] <= Q30_ONE - y2_ff;
      sm_ff[0] <= ymag2_ff;
      sn_ff[0] <= yneg2_ff;
      for (int k = 1; k <= SQRT_STAGES; k++) begin
         sv_ff[k]    <= sv_ff[k-1];
         sm_ff[k]    <= sm_ff[k-1];
         sn_ff[k]    <= sn_ff[k-1];
         srem_ff[k]  <= srem_in[k];
         sroot_ff[k] <= sroot_in[k];
      end
   end

   assign ymag = sm_ff[SQRT_STAGES];
   assign yneg = sn_ff[SQRT_STAGES];
   assign rad  = sroot_ff[SQRT_STAGES];

endmodule

@@ src/fsg_trig.sv @@
// Azimuth pipeline: golden-angle multiplication, octant folding and Horner
// Taylor series for sine and cosine in Q30. Uses fsg_pkg.
module fsg_trig #(
   parameter int IDX_W = fsg_pkg::INDEX_BITS_DEF
) (
   input  logic             clock,
   input  logic [IDX_W-1:0] idx_in,
   input  logic [15:0]      start_angle,
   output logic [30:0]      cos_mag,
   output logic             cos_neg,
   output logic [30:0]      sin_mag,
   output logic             sin_neg
);
   import fsg_pkg::*;

   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;
   localparam logic [1:0] QUAD_IV  = 2'd3;

   logic [IDX_W+31:0] gold_full;
   logic [31:0] prod_ff, ang_in, ang_ff;
   logic [29:0] wq;
   logic        swap_in;
   logic [29:0] fold_in, fold_ff;
   logic [60:0] a_full;
   logic [29:0] a_in;
   logic [29:0] a_ff   [0:8];
   logic [30:0] a2_in;
   logic [29:0] a2_ff  [0:7];
   logic        swp_ff [0:11];
   logic [1:0]  qd_ff  [0:11];

   logic [30:0] st1_ff, sp2_ff, st2_ff, sp3_ff, st3_ff, sp4_ff, st4_ff, s_ff, sdly_ff;
   logic [30:0] cu1_ff, cp2_ff, cu2_ff, cp3_ff, cu3_ff, cp4_ff, cu4_ff, cp5_ff, c_ff;
   logic [30:0] s0, c0;
   logic [30:0] cmag_in, smag_in, cmag_ff, smag_ff;
   logic        cneg_in, sneg_in, cneg_ff, sneg_ff;

   assign gold_full = (IDX_W+32)'(idx_in) * (IDX_W+32)'(GOLDEN_TURN);
   assign ang_in    = {start_angle, 16'h0000} + prod_ff;
   assign wq        = ang_ff[29:0];
   assign swap_in   = wq > 30'h2000_0000;
   assign fold_in   = swap_in ? 30'(Q30_ONE - {1'b0, wq}) : wq;
   assign a_full    = 61'(fold_ff) * 61'(TWO_PI_Q28);
   assign a_in      = 30'(a_full >> 30);
   assign a2_in     = mul_q30({1'b0, a_ff[0]}, {1'b0, a_ff[0]});

   assign s0 = swp_ff[11] ? c_ff : sdly_ff;
   assign c0 = swp_ff[11] ? sdly_ff : c_ff;

   always_comb begin
      case (qd_ff[11])
         QUAD_I: begin
            cmag_in = c0; cneg_in = 1'b0; smag_in = s0; sneg_in = 1'b0;
         end
         QUAD_II: begin
            cmag_in = s0; cneg_in = 1'b1; smag_in = c0; sneg_in = 1'b0;
         end
         QUAD_III: begin
            cmag_in = c0; cneg_in = 1'b1; smag_in = s0; sneg_in = 1'b1;
         end
         default: begin
            cmag_in = s0; cneg_in = 1'b0; smag_in = c0; sneg_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff   <= gold_full[31:0];
      ang_ff    <= ang_in;
      fold_ff   <= fold_in;
      swp_ff[0] <= swap_in;
      qd_ff[0]  <= ang_ff[31:30];
      for (int k = 1; k < 12; k++) begin
         swp_ff[k] <= swp_ff[k-1];
         qd_ff[k]  <= qd_ff[k-1];
      end
      a_ff[0] <= a_in;
      for (int k = 1; k < 9; k++) begin
         a_ff[k] <= a_ff[k-1];
      end
      a2_ff[0] <= a2_in[29:0];
      for (int k = 1; k < 8; k++) begin
         a2_ff[k] <= a2_ff[k-1];
      end

      st1_ff  <= Q30_ONE - 31'(div_rcp(a2_ff[0], RCP_72, SH_72));
      sp2_ff  <= mul_q30({1'b0, a2_ff[1]}, st1_ff);
      st2_ff  <= Q30_ONE - 31'(div_rcp(sp2_ff[29:0], RCP_42, SH_42));
      sp3_ff  <= mul_q30({1'b0, a2_ff[3]}, st2_ff);
      st3_ff  <= Q30_ONE - 31'(div_rcp(sp3_ff[29:0], RCP_20, SH_20));
      sp4_ff  <= mul_q30({1'b0, a2_ff[5]}, st3_ff);
      st4_ff  <= Q30_ONE - 31'(div_rcp(sp4_ff[29:0], RCP_6, SH_6));
      s_ff    <= mul_q30({1'b0, a_ff[8]}, st4_ff);
      sdly_ff <= s_ff;

      cu1_ff <= Q30_ONE - 31'(div_rcp(a2_ff[0], RCP_90, SH_90));
      cp2_ff <= mul_q30({1'b0, a2_ff[1]}, cu1_ff);
      cu2_ff <= Q30_ONE - 31'(div_rcp(cp2_ff[29:0], RCP_56, SH_56));
      cp3_ff <= mul_q30({1'b0, a2_ff[3]}, cu2_ff);
      cu3_ff <= Q30_ONE - 31'(div_rcp(cp3_ff[29:0], RCP_30, SH_30));
      cp4_ff <= mul_q30({1'b0, a2_ff[5]}, cu3_ff);
      cu4_ff <= Q30_ONE - 31'(div_rcp(cp4_ff[29:0], RCP_12, SH_12));
      cp5_ff <= mul_q30({1'b0, a2_ff[7]}, cu4_ff);
      c_ff   <= Q30_ONE - (cp5_ff >> 1);

      cmag_ff <= cmag_in;
      cneg_ff <= cneg_in;
      smag_ff <= smag_in;
      sneg_ff <= sneg_in;
   end

   assign cos_mag = cmag_ff;
   assign cos_neg = cneg_ff;
   assign sin_mag = smag_ff;
   assign sin_neg = sneg_ff;

endmodule
